[src/sct_pkg.sv]
// Shared types and constants for the speech chip register and timing block.
package sct_pkg;

  // Stream widths
  localparam int InDataW  = 32;  // addr(3) + data(8) + ticks(16), padded to bytes
  localparam int InUserW  = 2;   // func
  localparam int OutDataW = 16;  // read(8) + req + sounding + down, padded

  localparam int AddrW = 3;
  localparam int ByteW = 8;
  localparam int TickW = 16;
  localparam int CntW  = 19;
  localparam int FrameShift = 12;  // 4096 counter ticks per frame unit

  // Event codes carried on tuser
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Register addresses
  localparam logic [AddrW-1:0] REG_DUR_PHON = 3'd0;
  localparam logic [AddrW-1:0] REG_RATE     = 3'd2;
  localparam logic [AddrW-1:0] REG_CTL      = 3'd3;

  // Latched request modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;

  // Status byte when a request is pending
  localparam logic [ByteW-1:0] READ_REQ = 8'h80;

  typedef struct packed {
    logic [1:0]       func;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] wdata;
    logic [TickW-1:0] ticks;
  } sct_item_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             request;
    logic             sounding;
    logic             down;
  } sct_result_t;

endpackage

[src/sct_in_stage.sv]
// Input register: captures one beat from the slave stream and unpacks it.
module sct_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [sct_pkg::InDataW-1:0] s_axis_tdata,  // addr[2:0], data[10:3], ticks[26:11]
  input  logic [sct_pkg::InUserW-1:0] s_axis_tuser,  // func[1:0]
  input  logic                       advance_i,
  output logic                       valid_o,
  output sct_pkg::sct_item_t         item_o
);
  import sct_pkg::*;

  logic      valid_q, valid_d;
  sct_item_t item_q, item_d;
  logic      take;

  // Room when empty or when the held beat moves on this cycle
  assign s_axis_tready = !valid_q || advance_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.func  = s_axis_tuser;
    item_d.addr  = s_axis_tdata[2:0];
    item_d.wdata = s_axis_tdata[10:3];
    item_d.ticks = s_axis_tdata[26:11];
    valid_d      = take || (valid_q && !advance_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[src/sct_core.sv]
// Register file, mode latch and phoneme countdown; one event per cycle while advanced.
module sct_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  sct_pkg::sct_item_t  item_i,
  output sct_pkg::sct_result_t result_o
);
  import sct_pkg::*;

  // Only the register bits that affect behavior are kept: duration, rate, control
  logic [1:0]      dur_q, dur_d;
  logic [3:0]      rate_q, rate_d;
  logic            down_q, down_d;
  logic [1:0]      mode_q, mode_d;
  logic            req_q, req_d;
  logic            sound_q, sound_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [4:0]      rate_span;
  logic [2:0]      dur_span;
  logic [6:0]      units;
  logic [CntW-1:0] load_cnt;
  logic [CntW-1:0] ticks_ext;
  logic [ByteW-1:0] rd;

  // Countdown length for a phoneme started with the new duration bits (frame mode uses the rate alone)
  always_comb begin
    rate_span = 5'd16 - {1'b0, rate_q};
    dur_span  = 3'd4 - {1'b0, item_i.wdata[7:6]};
    if (mode_q == MODE_FRAME) begin
      units = 7'(rate_span);
    end else begin
      units = 7'(rate_span) * 7'(dur_span);
    end
    load_cnt  = {units, {FrameShift{1'b0}}};
    ticks_ext = CntW'(item_i.ticks);
  end

  // Next state for the event in the input register
  always_comb begin
    dur_d   = dur_q;
    rate_d  = rate_q;
    down_d  = down_q;
    mode_d  = mode_q;
    req_d   = req_q;
    sound_d = sound_q;
    cnt_d   = cnt_q;
    rd      = '0;
    unique case (item_i.func)
      FUNC_WRITE: begin
        unique case (item_i.addr)
          REG_DUR_PHON: begin
            dur_d = item_i.wdata[7:6];
            if (!down_q) begin
              cnt_d   = load_cnt;
              sound_d = (load_cnt != '0);
              req_d   = 1'b0;
            end
          end
          REG_RATE: begin
            rate_d = item_i.wdata[7:4];
          end
          REG_CTL: begin
            down_d = item_i.wdata[7];
            // Leaving power-down latches the mode; either edge clears timing
            if (down_q && !item_i.wdata[7]) begin
              mode_d = dur_q;
            end
            if (down_q != item_i.wdata[7]) begin
              req_d   = 1'b0;
              sound_d = 1'b0;
              cnt_d   = '0;
            end
          end
          default: begin
            // inflection and filter bytes are not observable
          end
        endcase
      end
      FUNC_READ: begin
        rd = req_q ? READ_REQ : '0;
      end
      FUNC_TICK: begin
        if (sound_q && !down_q) begin
          if (ticks_ext >= cnt_q) begin
            cnt_d   = '0;
            sound_d = 1'b0;
            if (mode_q != MODE_OFF) begin
              req_d = 1'b1;
            end
          end else begin
            cnt_d = cnt_q - ticks_ext;
          end
        end
      end
      default: begin
        // unused event code: report flags only
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q   <= '0;
      rate_q  <= '0;
      down_q  <= 1'b1;
      mode_q  <= MODE_OFF;
      req_q   <= 1'b0;
      sound_q <= 1'b0;
      cnt_q   <= '0;
    end else if (advance_i) begin
      dur_q   <= dur_d;
      rate_q  <= rate_d;
      down_q  <= down_d;
      mode_q  <= mode_d;
      req_q   <= req_d;
      sound_q <= sound_d;
      cnt_q   <= cnt_d;
    end
  end

  // Flags as they stand after the event
  always_comb begin
    result_o.read_data = rd;
    result_o.request   = req_d;
    result_o.sounding  = sound_d;
    result_o.down      = down_d;
  end

endmodule

[src/sct_out_stage.sv]
// Result register: holds one result beat for the master stream.
module sct_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_valid_i,
  input  sct_pkg::sct_result_t        result_i,
  output logic                        free_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [sct_pkg::OutDataW-1:0] m_axis_tdata  // read[7:0], req[8], sounding[9], down[10]
);
  import sct_pkg::*;

  logic        valid_q, valid_d;
  logic        load;
  sct_result_t res_q;

  assign free_o = !valid_q || m_axis_tready;
  assign load   = load_valid_i && free_o;

  always_comb begin
    valid_d = load || (valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'b0, res_q.down, res_q.sounding, res_q.request, res_q.read_data};

endmodule

[src/speech_chip_register_timing.sv]
// Each beat passes the input register, then the core, then the result register.
// One beat per cycle unless the master stalls; write, read and tick each finish in one pass.
// The phoneme countdown is one 19-bit compare and subtract per tick beat.
// Reset (rst_ni low, asynchronous): control bit set (powered down), mode off,
// request, sounding and countdown cleared, both stream stages empty.
module speech_chip_register_timing (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [sct_pkg::InDataW-1:0]  s_axis_tdata,  // addr[2:0], data[10:3], ticks[26:11]
  input  logic [sct_pkg::InUserW-1:0]  s_axis_tuser,  // func[1:0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [sct_pkg::OutDataW-1:0] m_axis_tdata  // read[7:0], req[8], sounding[9], down[10]
);
  import sct_pkg::*;

  logic        item_valid;
  sct_item_t   item;
  sct_result_t result;
  logic        out_free;
  logic        advance;

  assign advance = item_valid && out_free;

  sct_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance_i     (advance),
    .valid_o       (item_valid),
    .item_o        (item)
  );

  sct_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result)
  );

  sct_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_valid_i  (item_valid),
    .result_i      (result),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[src/sct_checker.sv]
// Port-level checks for the speech chip register and timing block.
module sct_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [sct_pkg::OutDataW-1:0] m_axis_tdata
);
  import sct_pkg::*;

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Status byte is 0x80 or 0, and 0x80 only with a pending request
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] == 7'd0) && (!m_axis_tdata[7] || m_axis_tdata[8]))
    else $error("bad status byte");

  // Power-down leaves nothing timing and no request
  a_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10] |-> !m_axis_tdata[9] && !m_axis_tdata[8])
    else $error("activity while powered down");

  // A request is only raised once the phoneme stopped sounding
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
    else $error("request while sounding");

endmodule

bind speech_chip_register_timing sct_checker u_sct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
